// ===== rtl/core/abae_pkg.sv =====
// shared types and constants for the arena bump allocator with epoch stack
// no dependencies
`default_nettype none

package abae_pkg;

	// request codes
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_BEGIN = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;

	// error codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_NOMEM = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;
	localparam logic [1:0] ERR_TOKEN = 2'd3;

	// configuration register indexes
	localparam logic CFG_CHUNK_SIZE  = 1'b0;
	localparam logic CFG_CHUNK_LIMIT = 1'b1;

	// reset values of the configuration registers
	localparam logic [30:0] CHUNK_SIZE_RST  = 31'd67108864;
	localparam logic [15:0] CHUNK_LIMIT_RST = 16'd65535;

	// offset alignment, a power of two
	localparam int unsigned   ALIGN_LOG2  = 4;
	localparam int unsigned   ALIGN_BYTES = 1 << ALIGN_LOG2;
	localparam logic [31:0]   ALIGN_ADD   = 32'(ALIGN_BYTES - 1);
	localparam logic [31:0]   ALIGN_MASK  = ~ALIGN_ADD;

	// input item
	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] size_bytes;
		logic signed [31:0] epoch_token;
	} req_t;

	// result item
	typedef struct packed {
		logic [15:0] chunk_number;
		logic [30:0] byte_offset;
		logic [12:0] depth_token;
		logic [1:0]  error_code;
	} rsp_t;

	// one saved stack frame
	typedef struct packed {
		logic [15:0] chunk;
		logic [30:0] offset;
		logic [30:0] capacity;
	} frame_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/arena_bump_allocator_epochs.sv =====
// arena bump allocator with epoch stack: each request is handled in a capture
// step, which registers the request and reads the stacked frame, then an
// execute step, which loads the result register and waits while a held
// result is stalled; a new request is not accepted until the last one has
// executed. reset clears allocator state and restores the configuration
// reset values; the frame stack memory is not cleared and needs no clearing pass.
// depends on abae_pkg, abae_ctrl, abae_dp
`default_nettype none

module arena_bump_allocator_epochs #(
	parameter int unsigned STACK_DEPTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  abae_pkg::req_t   req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output abae_pkg::rsp_t   rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [30:0] cfg_data
);

	abae_pkg::ctrl_cmd_t  cmd;
	abae_pkg::dp_status_t status;

	// configuration is only to be written while idle; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	// controller
	abae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	abae_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/core/abae_ctrl.sv =====
// controller state machine: sequences capture and execution of one request
// depends on abae_pkg
`default_nettype none

module abae_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  abae_pkg::dp_status_t   status,
	output abae_pkg::ctrl_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	// command decode
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && req_valid;
		cmd.exec    = (state_q == ST_EXEC) && status.out_free;
		req_stall   = (state_q != ST_IDLE);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/abae_dp.sv =====
// datapath: allocator state, configuration, frame stack memory, result register
// depends on abae_pkg
`default_nettype none

module abae_dp #(
	parameter int unsigned STACK_DEPTH = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  abae_pkg::req_t        req,
	input  abae_pkg::ctrl_cmd_t   cmd,
	output abae_pkg::dp_status_t  status,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [30:0]      cfg_data,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output abae_pkg::rsp_t        rsp
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

	localparam logic [31:0] ALIGN_ADD_C  = abae_pkg::ALIGN_ADD;
	localparam logic [31:0] ALIGN_MASK_C = abae_pkg::ALIGN_MASK;

	// frame stack
	abae_pkg::frame_t frame_mem [STACK_DEPTH];

	abae_pkg::req_t   req_q;
	abae_pkg::frame_t rd_q;
	abae_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic [30:0]      csize_q;
	logic [15:0]      climit_q;

	logic [15:0]      chunk_q;
	logic             open_q;
	logic [15:0]      opened_q;
	logic [30:0]      offset_q;
	logic [30:0]      cap_q;
	logic [DW-1:0]    depth_q;

	logic [15:0]      chunk_n;
	logic             open_n;
	logic [15:0]      opened_n;
	logic [30:0]      offset_n;
	logic [30:0]      cap_n;
	logic [DW-1:0]    depth_n;
	abae_pkg::rsp_t   rsp_n;
	logic             push;
	abae_pkg::frame_t push_frame;

	logic [AW-1:0]    rd_addr;
	logic [30:0]      size31;
	logic             neg;
	logic [31:0]      aligned;
	logic [32:0]      sum;
	logic             fits;
	logic             can_open;
	logic [30:0]      grow_cap;
	logic [15:0]      opened_inc;
	logic [31:0]      tok;
	logic             bad_tok;
	logic             full;
	logic [DW-1:0]    depth_inc;
	logic [DW-1:0]    depth_pop;
	logic [31:0]      depth_inc_ext;
	logic [31:0]      depth_pop_ext;

	assign status.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;

	// read address of the frame an epoch end would restore
	assign rd_addr = req.epoch_token[AW-1:0] - AW'(1);

	// shared arithmetic
	always_comb begin
		size31        = req_q.size_bytes[30:0];
		neg           = req_q.size_bytes[31];
		aligned       = ({1'b0, offset_q} + ALIGN_ADD_C) & ALIGN_MASK_C;
		sum           = {1'b0, aligned} + {2'b00, size31};
		fits          = open_q && (sum <= {2'b00, cap_q});
		can_open      = opened_q < climit_q;
		grow_cap      = (size31 > csize_q) ? size31 : csize_q;
		opened_inc    = opened_q + 16'd1;
		tok           = req_q.epoch_token;
		bad_tok       = tok[31] || (tok == 32'd0) || (tok > 32'(depth_q));
		full          = depth_q >= DW'(STACK_DEPTH);
		depth_inc     = depth_q + DW'(1);
		depth_pop     = tok[DW-1:0] - DW'(1);
		depth_inc_ext = 32'(depth_inc);
		depth_pop_ext = 32'(depth_pop);
	end

	// request execution
	always_comb begin
		chunk_n    = chunk_q;
		open_n     = open_q;
		opened_n   = opened_q;
		offset_n   = offset_q;
		cap_n      = cap_q;
		depth_n    = depth_q;
		push       = 1'b0;
		push_frame = '{chunk: chunk_q, offset: offset_q, capacity: cap_q};
		rsp_n      = '0;
		unique case (req_q.req_type)
			abae_pkg::REQ_ALLOC: begin
				if (neg) begin
					rsp_n.error_code = abae_pkg::ERR_NOMEM;
				end else if (fits) begin
					offset_n           = sum[30:0];
					rsp_n.chunk_number = chunk_q;
					rsp_n.byte_offset  = aligned[30:0];
				end else if (!can_open) begin
					rsp_n.error_code = abae_pkg::ERR_NOMEM;
				end else begin
					chunk_n            = opened_q;
					opened_n           = opened_inc;
					open_n             = 1'b1;
					cap_n              = grow_cap;
					offset_n           = size31;
					rsp_n.chunk_number = opened_q;
				end
			end
			abae_pkg::REQ_BEGIN: begin
				if (!open_q && !can_open) begin
					rsp_n.error_code = abae_pkg::ERR_NOMEM;
				end else if (full) begin
					rsp_n.error_code = abae_pkg::ERR_FULL;
				end else begin
					// open the first chunk if none exists yet
					if (!open_q) begin
						chunk_n    = opened_q;
						opened_n   = opened_inc;
						open_n     = 1'b1;
						cap_n      = csize_q;
						offset_n   = 31'd0;
						push_frame = '{chunk: opened_q, offset: 31'd0, capacity: csize_q};
					end
					push               = 1'b1;
					depth_n            = depth_inc;
					rsp_n.chunk_number = push_frame.chunk;
					rsp_n.byte_offset  = push_frame.offset;
					rsp_n.depth_token  = depth_inc_ext[12:0];
				end
			end
			abae_pkg::REQ_END: begin
				if (bad_tok) begin
					rsp_n.error_code = abae_pkg::ERR_TOKEN;
				end else begin
					depth_n            = depth_pop;
					chunk_n            = rd_q.chunk;
					offset_n           = rd_q.offset;
					cap_n              = rd_q.capacity;
					rsp_n.chunk_number = rd_q.chunk;
					rsp_n.byte_offset  = rd_q.offset;
					rsp_n.depth_token  = depth_pop_ext[12:0];
				end
			end
			default: begin
				rsp_n = '0;
			end
		endcase
	end

	// request capture, frame read, frame push and result register load
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
			rd_q  <= frame_mem[rd_addr];
		end
		if (cmd.exec && push) begin
			frame_mem[depth_q[AW-1:0]] <= push_frame;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_n;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csize_q  <= abae_pkg::CHUNK_SIZE_RST;
			climit_q <= abae_pkg::CHUNK_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == abae_pkg::CFG_CHUNK_SIZE) begin
				csize_q <= cfg_data;
			end else begin
				climit_q <= cfg_data[15:0];
			end
		end
	end

	// allocator state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q     <= '0;
			open_q      <= 1'b0;
			opened_q    <= '0;
			offset_q    <= '0;
			cap_q       <= '0;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				chunk_q  <= chunk_n;
				open_q   <= open_n;
				opened_q <= opened_n;
				offset_q <= offset_n;
				cap_q    <= cap_n;
				depth_q  <= depth_n;
			end
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
